// ===== rtl/core/point_in_polygon_filter_core_macros.svh =====
// Assertion macros shared by the core.
`ifndef POINT_IN_POLYGON_FILTER_CORE_MACROS_SVH
`define POINT_IN_POLYGON_FILTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define PIPF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("point_in_polygon_filter_core: assertion failed");
`define PIPF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("point_in_polygon_filter_core: assertion failed");
`else
`define PIPF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PIPF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/core/pipf_pkg.sv =====
package pipf_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int INDEX_BITS       = 4;
    localparam int COUNT_BITS       = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;       // write the accepted vertex
        logic load_point;  // latch the accepted point, clear the flag
        logic rd_en;       // read one vertex
        logic rd_first;    // this read only primes the previous vertex
        logic load_out;    // move point and flag into the output register
    } pipf_cmd_t;

endpackage

// ===== rtl/core/pipf_in_if.sv =====
interface pipf_in_if
    import pipf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

// ===== rtl/core/pipf_out_if.sv =====
interface pipf_out_if
    import pipf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         inside_res;

    modport source (output valid, point_x, point_y, inside_res, input ready);
    modport sink   (input valid, point_x, point_y, inside_res, output ready);
endinterface

// ===== rtl/core/pipf_ram.sv =====
module pipf_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/pipf_ctrl.sv =====
module pipf_ctrl
    import pipf_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_op,
    output logic                             in_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    input  logic [COUNT_BITS-1:0]            vertex_count,
    output pipf_cmd_t                        cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]  rd_addr
);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_DR1  = 3'd2;
    localparam logic [2:0] S_DR2  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] n;
    logic [CW-1:0] addr_w;
    logic          accept;

    // clamp the count to the table depth
    always_comb
    begin
        if (int'(vertex_count) > MAX_VERTICES)
        begin
            n = CW'(MAX_VERTICES);
        end
        else
        begin
            n = CW'(vertex_count);
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // first read fetches the closing vertex, then vertices 0 .. n-1
    assign addr_w   = (k_reg == '0) ? (n - CW'(1)) : (k_reg - CW'(1));
    assign rd_addr  = addr_w[$clog2(MAX_VERTICES)-1:0];

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.load_point = 1'b1;
                        k_next         = '0;
                        state_next     = (n == '0) ? S_FIN : S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (k_reg == '0);
                k_next       = k_reg + CW'(1);
                if (k_reg == n)
                begin
                    state_next = S_DR1;
                end
            end
            S_DR1:
            begin
                state_next = S_DR2;
            end
            S_DR2:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/core/pipf_dp.sv =====
module pipf_dp
    import pipf_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pipf_cmd_t                        cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]  rd_addr,
    input  logic [INDEX_BITS-1:0]            vertex_index,
    input  logic signed [COORD_BITS-1:0]     coord_x,
    input  logic signed [COORD_BITS-1:0]     coord_y,
    output logic signed [COORD_BITS-1:0]     point_x,
    output logic signed [COORD_BITS-1:0]     point_y,
    output logic                             inside_res
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int EW = INDEX_BITS + AW;

    logic [EW-1:0]          idx_ext;
    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;
    logic [2*CB-1:0]        rdata;

    logic signed [CB-1:0]   tx_reg, ty_reg;
    logic signed [CB-1:0]   xj_reg, yj_reg;
    logic signed [CB-1:0]   xi, yi;
    logic                   v1_reg, first1_reg;

    logic signed [DW-1:0]   dx_t, dy_e, dx_e, dy_t;
    logic signed [PW-1:0]   lhs_reg, rhs_reg;
    logic                   p_valid_reg, straddle_reg, dy_pos_reg;
    logic                   left;
    logic                   flag_reg;

    logic signed [CB-1:0]   out_x_reg, out_y_reg;
    logic                   out_in_reg;

    // drop writes beyond the table
    assign idx_ext = {{AW{1'b0}}, vertex_index};
    assign wr_ok   = idx_ext < EW'(MAX_VERTICES);
    assign wr_addr = idx_ext[AW-1:0];

    pipf_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en && wr_ok),
        .waddr (wr_addr),
        .wdata ({coord_y, coord_x}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign xi = rdata[CB-1:0];
    assign yi = rdata[2*CB-1:CB];

    // edge differences, one bit wider so nothing wraps
    assign dx_t = {tx_reg[CB-1], tx_reg} - {xi[CB-1], xi};
    assign dy_e = {yj_reg[CB-1], yj_reg} - {yi[CB-1], yi};
    assign dx_e = {xj_reg[CB-1], xj_reg} - {xi[CB-1], xi};
    assign dy_t = {ty_reg[CB-1], ty_reg} - {yi[CB-1], yi};

    // point is left of the edge when the cross products order as dy's sign says
    assign left = dy_pos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg      <= cmd.rd_en;
            p_valid_reg <= v1_reg && !first1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.rd_first;
        if (cmd.load_point)
        begin
            tx_reg <= coord_x;
            ty_reg <= coord_y;
        end
        if (v1_reg)
        begin
            xj_reg       <= xi;
            yj_reg       <= yi;
            lhs_reg      <= PW'(dx_t) * PW'(dy_e);
            rhs_reg      <= PW'(dx_e) * PW'(dy_t);
            straddle_reg <= (yi > ty_reg) != (yj_reg > ty_reg);
            dy_pos_reg   <= !dy_e[DW-1];
        end
        if (cmd.load_point)
        begin
            flag_reg <= 1'b0;
        end
        else if (p_valid_reg && straddle_reg && left)
        begin
            flag_reg <= !flag_reg;
        end
        if (cmd.load_out)
        begin
            out_x_reg  <= tx_reg;
            out_y_reg  <= ty_reg;
            out_in_reg <= flag_reg;
        end
    end

    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign inside_res = out_in_reg;
endmodule

// ===== rtl/core/point_in_polygon_filter_core.sv =====
// Point-in-polygon filter. Items on cmd with op = OP_WRITE store one vertex of the
// footprint polygon (slots at or above MAX_VERTICES are dropped) and give no result;
// items with op = OP_TEST carry a point and give one result on res: the point
// echoed and inside_res, the even-odd crossing parity over the first vertex_count
// vertices (a count above MAX_VERTICES is clamped). Points with inside_res set lie
// inside the footprint and should be dropped. A vertex write leaves the block ready;
// a test blocks further items from its acceptance until its result is loaded: the
// edge walk reads the closing vertex and then vertices 0 .. n-1, with n the clamped
// vertex count (an empty polygon skips the walk), one vertex table read per cycle
// feeding one pair of exact cross-product multipliers. The finished result waits in
// an output register, so a vertex write or a new test is accepted while the previous
// result is still waiting to be taken. Write vertex_count only while the block is idle.
`include "point_in_polygon_filter_core_macros.svh"

module point_in_polygon_filter_core
    import pipf_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    pipf_in_if.sink               cmd,
    pipf_out_if.source            res
);
    logic [COUNT_BITS-1:0]          vertex_count_reg;
    pipf_cmd_t                      ctl_cmd;
    logic [$clog2(MAX_VERTICES)-1:0] rd_addr;

    // hold the vertex count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // sequence the edge walk and own both handshakes
    pipf_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd.valid),
        .in_op        (cmd.op),
        .in_ready     (cmd.ready),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .vertex_count (vertex_count_reg),
        .cmd          (ctl_cmd),
        .rd_addr      (rd_addr)
    );

    // vertex table, cross products and the parity flag
    pipf_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .rd_addr      (rd_addr),
        .vertex_index (cmd.vertex_index),
        .coord_x      (cmd.coord_x),
        .coord_y      (cmd.coord_y),
        .point_x      (res.point_x),
        .point_y      (res.point_y),
        .inside_res   (res.inside_res)
    );

    // a test item blocks further items until its result is loaded
    `PIPF_ASSERT_NXT(a_test_blocks, clk, rst_n, cmd.valid && cmd.ready && cmd.op == OP_TEST, !cmd.ready)
    // a result is loaded only when the output register is free
    `PIPF_ASSERT_IMP(a_load_free, clk, rst_n, ctl_cmd.load_out, !res.valid || res.ready)
    // a loaded result shows on the next cycle
    `PIPF_ASSERT_NXT(a_load_shows, clk, rst_n, ctl_cmd.load_out, res.valid)
    // never read and write the table together
    `PIPF_ASSERT_IMP(a_rd_wr_apart, clk, rst_n, ctl_cmd.rd_en, !ctl_cmd.wr_en && !cmd.ready)
endmodule
